[rtl/rtcs_pkg.sv]
// ----------------------------------------------------------------------------
// rtcs_pkg: shared types and constants for the rectangle table scanner
// Sizes of the table and the coordinates, command and status codes, the entry
// layout, the shared unit's request and response words, and helper functions.
// ----------------------------------------------------------------------------
package rtcs_pkg;

    // Table size and coordinate range.
    localparam int MAX_ENTRIES = 64;
    localparam int COORD_BITS  = 16;
    localparam int COORD_W     = COORD_BITS;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // Fixed widths of the channel fields.
    localparam int POS_W   = 16;
    localparam int DIM_W   = 15;
    localparam int KIND_W  = 8;
    localparam int SLOT_W  = 6;
    localparam int HSLOT_W = 6;
    localparam int COUNT_W = 7;

    // Width of the arithmetic: edge sums and shifted coordinates never wrap.
    localparam int CALC_W  = ((COORD_W > POS_W) ? COORD_W : POS_W) + 2;
    localparam int CMP_W   = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

    // Saturation bounds of a coordinate.
    localparam logic signed [CALC_W-1:0] COORD_MAX =
        CALC_W'((64'sd1 <<< (COORD_W - 1)) - 64'sd1);
    localparam logic signed [CALC_W-1:0] COORD_MIN = ~COORD_MAX;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_MOVE   = 2'd2,
        CMD_QUERY  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_BAD_SLOT = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DONE
    } t_state;

    // One table entry as held in the memory.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [DIM_W-1:0]          w;
        logic [DIM_W-1:0]          h;
        logic [KIND_W-1:0]         kind;
    } t_entry;

    // Query rectangle with its far edges already summed.
    typedef struct packed {
        logic signed [CALC_W-1:0] x;
        logic signed [CALC_W-1:0] y;
        logic signed [CALC_W-1:0] r;
        logic signed [CALC_W-1:0] b;
    } t_query;

    // Entry handed to the shared unit.
    typedef struct packed {
        logic             vld;
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
        t_entry           entry;
    } t_unit_req;

    // Result of the shared unit: overlap flag and the entry to write back.
    typedef struct packed {
        logic             vld;
        logic [IDX_W-1:0] idx;
        logic             hit;
        t_entry           entry;
    } t_unit_rsp;

    // Sign-extend a channel coordinate to the arithmetic width.
    function automatic logic signed [CALC_W-1:0] sext_pos(input logic signed [POS_W-1:0] v);
        return CALC_W'(v);
    endfunction

    // Saturate a value to the signed coordinate range.
    function automatic logic signed [COORD_W-1:0] clamp_coord(
        input logic signed [CALC_W-1:0] v
    );
        logic signed [CALC_W-1:0] s;
        if (v > COORD_MAX) begin
            s = COORD_MAX;
        end else if (v < COORD_MIN) begin
            s = COORD_MIN;
        end else begin
            s = v;
        end
        return s[COORD_W-1:0];
    endfunction

endpackage

[rtl/rtcs_if.sv]
// ----------------------------------------------------------------------------
// rtcs_if: command and response channels of the rectangle table scanner
// Each channel carries valid, ready and the payload of one word.
// ----------------------------------------------------------------------------
interface rtcs_cmd_if import rtcs_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [DIM_W-1:0]         width;
    logic [DIM_W-1:0]         height;
    logic [KIND_W-1:0]        kind;
    logic [SLOT_W-1:0]        slot;
    logic signed [POS_W-1:0]  delta_x;
    logic signed [POS_W-1:0]  delta_y;

    modport source (
        output valid, command, pos_x, pos_y, width, height, kind, slot, delta_x, delta_y,
        input  ready
    );
    modport sink (
        input  valid, command, pos_x, pos_y, width, height, kind, slot, delta_x, delta_y,
        output ready
    );
endinterface

interface rtcs_rsp_if import rtcs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               hit;
    logic [HSLOT_W-1:0] hit_slot;
    logic [COUNT_W-1:0] entry_count;
    logic [1:0]         status;

    modport source (output valid, hit, hit_slot, entry_count, status, input ready);
    modport sink   (input  valid, hit, hit_slot, entry_count, status, output ready);
endinterface

[rtl/rtcs_store.sv]
// ----------------------------------------------------------------------------
// rtcs_store: entry memory of the rectangle table
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rtcs_store import rtcs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_entry           i_wr_data,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_entry           o_rd_data
);

    t_entry r_mem [MAX_ENTRIES];
    t_entry r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/rtcs_unit.sv]
// ----------------------------------------------------------------------------
// rtcs_unit: shared two-stage arithmetic unit
// The first stage adds one operand pair per axis: the far edges of an entry
// for a query, or the shifted position for a move. The second stage runs the
// strict overlap tests or saturates the moved coordinates.
// ----------------------------------------------------------------------------
module rtcs_unit import rtcs_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_unit_req               i_req,
    input  t_query                  i_query,
    input  logic signed [POS_W-1:0] i_dx,
    input  logic signed [POS_W-1:0] i_dy,
    output t_unit_rsp               o_rsp
);

    logic signed [CALC_W-1:0] op_a, op_b, op_c, op_d;
    logic signed [CALC_W-1:0] n_sum_a, n_sum_b;

    logic                     r_vld;
    t_cmd                     r_cmd;
    logic [IDX_W-1:0]         r_idx;
    t_entry                   r_entry;
    logic signed [CALC_W-1:0] r_sum_a, r_sum_b;

    logic signed [CALC_W-1:0] mx, my;
    logic                     xo, yo;

    // First stage: operand selection and the two adders.
    always_comb begin
        op_a = CALC_W'($signed(i_req.entry.x));
        op_c = CALC_W'($signed(i_req.entry.y));
        if (i_req.cmd == CMD_MOVE) begin
            op_b = sext_pos(i_dx);
            op_d = sext_pos(i_dy);
        end else begin
            op_b = CALC_W'(i_req.entry.w);
            op_d = CALC_W'(i_req.entry.h);
        end
        n_sum_a = op_a + op_b;
        n_sum_b = op_c + op_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_req.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= i_req.cmd;
        r_idx   <= i_req.idx;
        r_entry <= i_req.entry;
        r_sum_a <= n_sum_a;
        r_sum_b <= n_sum_b;
    end

    // Second stage: strict per-axis overlap tests, or saturation for a move.
    always_comb begin
        mx = CALC_W'($signed(r_entry.x));
        my = CALC_W'($signed(r_entry.y));

        xo = (i_query.r < r_sum_a && i_query.r > mx)
          || (i_query.x > mx && i_query.x < r_sum_a)
          || (i_query.x < mx && i_query.r > r_sum_a);
        yo = (i_query.y < r_sum_b && i_query.y > my)
          || (i_query.b < r_sum_b && i_query.b > my)
          || (i_query.y < my && i_query.b > r_sum_b);

        o_rsp.vld   = r_vld;
        o_rsp.idx   = r_idx;
        o_rsp.hit   = (r_cmd == CMD_QUERY) && xo && yo;
        o_rsp.entry = r_entry;
        if (r_cmd == CMD_MOVE) begin
            o_rsp.entry.x = clamp_coord(r_sum_a);
            o_rsp.entry.y = clamp_coord(r_sum_b);
        end
    end

endmodule

[rtl/rect_table_collision_scan.sv]
// ----------------------------------------------------------------------------
// rect_table_collision_scan: ordered rectangle table with a first-hit scan
// Adds, deletes, moves and queries axis-aligned rectangles held in one
// memory, walking the table one entry per cycle through a shared unit.
//
//   channel    direction  word contents
//   i_cmd_ch   in         command, pos_x, pos_y, width, height, kind, slot,
//                         delta_x, delta_y
//   o_rsp_ch   out        hit, hit_slot, entry_count, status
//
// Add and a rejected delete answer without a scan. Move and query walk the
// table from its start, a query stopping at its first hit; a delete walks from
// the entry after the slot to the end, moving each entry down by one. One
// memory read a cycle sets the pace.
// Reset clears the entry count; memory contents are only read once written.
// A stalled response holds in its register; the next command runs, then waits.
// ----------------------------------------------------------------------------
module rect_table_collision_scan import rtcs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtcs_cmd_if.sink    i_cmd_ch,
    rtcs_rsp_if.source  o_rsp_ch
);

    // Control registers.
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_ptr, n_ptr;
    logic             r_rd_vld, n_rd_vld;
    logic             r_out_vld, n_out_vld;

    // Payload registers.
    t_cmd                     r_cmd, n_cmd;
    logic signed [COORD_W-1:0] r_qx, n_qx, r_qy, n_qy;
    logic [DIM_W-1:0]         r_qw, n_qw, r_qh, n_qh;
    logic [KIND_W-1:0]        r_kind, n_kind;
    logic [SLOT_W-1:0]        r_slot, n_slot;
    logic signed [POS_W-1:0]  r_dx, n_dx, r_dy, n_dy;
    t_query                   r_query, n_query;
    logic [IDX_W-1:0]         r_rd_idx, n_rd_idx;
    logic                     r_hit, n_hit;
    logic [IDX_W-1:0]         r_hit_idx, n_hit_idx;
    t_status                  r_status, n_status;
    logic                     r_out_hit, n_out_hit;
    logic [IDX_W-1:0]         r_out_idx, n_out_idx;
    logic [CNT_W-1:0]         r_out_count, n_out_count;
    t_status                  r_out_status, n_out_status;

    // Memory ports and shared unit connections.
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    t_entry           wr_data, rd_data;
    t_unit_req        unit_req;
    t_unit_rsp        unit_rsp;
    logic             in_accept;

    rtcs_store u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Entries read in the previous cycle enter the shared unit.
    always_comb begin
        unit_req.vld   = r_rd_vld && (r_state == S_SCAN);
        unit_req.cmd   = r_cmd;
        unit_req.idx   = r_rd_idx;
        unit_req.entry = rd_data;
    end

    rtcs_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (unit_req),
        .i_query (r_query),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .o_rsp   (unit_rsp)
    );

    assign in_accept = i_cmd_ch.valid && i_cmd_ch.ready;

    // Sequencer: next state, memory ports and result registers.
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_ptr        = r_ptr;
        n_out_vld    = r_out_vld && !o_rsp_ch.ready;
        n_cmd        = r_cmd;
        n_qx         = r_qx;
        n_qy         = r_qy;
        n_qw         = r_qw;
        n_qh         = r_qh;
        n_kind       = r_kind;
        n_slot       = r_slot;
        n_dx         = r_dx;
        n_dy         = r_dy;
        n_query      = r_query;
        n_hit        = r_hit;
        n_hit_idx    = r_hit_idx;
        n_status     = r_status;
        n_out_hit    = r_out_hit;
        n_out_idx    = r_out_idx;
        n_out_count  = r_out_count;
        n_out_status = r_out_status;

        i_cmd_ch.ready = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = r_count[IDX_W-1:0];
        wr_data        = '{x: r_qx, y: r_qy, w: r_qw, h: r_qh, kind: r_kind};
        rd_en          = 1'b0;
        rd_addr        = r_ptr[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                // Take a command word and saturate its position.
                i_cmd_ch.ready = 1'b1;
                if (i_cmd_ch.valid) begin
                    n_cmd   = t_cmd'(i_cmd_ch.command);
                    n_qx    = clamp_coord(sext_pos(i_cmd_ch.pos_x));
                    n_qy    = clamp_coord(sext_pos(i_cmd_ch.pos_y));
                    n_qw    = i_cmd_ch.width;
                    n_qh    = i_cmd_ch.height;
                    n_kind  = i_cmd_ch.kind;
                    n_slot  = i_cmd_ch.slot;
                    n_dx    = i_cmd_ch.delta_x;
                    n_dy    = i_cmd_ch.delta_y;
                    n_state = S_EXEC;
                end
            end

            S_EXEC: begin
                // Prepare the query edges and handle add or set up the scan.
                n_hit     = 1'b0;
                n_hit_idx = '0;
                n_status  = ST_OK;
                n_query.x = CALC_W'(r_qx);
                n_query.y = CALC_W'(r_qy);
                n_query.r = CALC_W'(r_qx) + CALC_W'(r_qw);
                n_query.b = CALC_W'(r_qy) + CALC_W'(r_qh);
                n_ptr     = '0;
                unique case (r_cmd)
                    CMD_ADD: begin
                        if (r_count == CNT_W'(MAX_ENTRIES)) begin
                            n_status = ST_FULL;
                        end else begin
                            wr_en   = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                        n_state = S_DONE;
                    end
                    CMD_DELETE: begin
                        if (CMP_W'(r_slot) >= CMP_W'(r_count)) begin
                            n_status = ST_BAD_SLOT;
                            n_state  = S_DONE;
                        end else begin
                            n_ptr   = CNT_W'(r_slot) + CNT_W'(1);
                            n_state = S_SCAN;
                        end
                    end
                    CMD_MOVE, CMD_QUERY: begin
                        n_state = S_SCAN;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end

            S_SCAN: begin
                // Issue one read per cycle until the end of the table.
                if (r_ptr < r_count) begin
                    rd_en = 1'b1;
                    n_ptr = r_ptr + CNT_W'(1);
                end
                // Act on the word leaving the shared unit.
                if (unit_rsp.vld) begin
                    wr_data = unit_rsp.entry;
                    unique case (r_cmd)
                        CMD_DELETE: begin
                            wr_en   = 1'b1;
                            wr_addr = unit_rsp.idx - IDX_W'(1);
                        end
                        CMD_MOVE: begin
                            wr_en   = 1'b1;
                            wr_addr = unit_rsp.idx;
                        end
                        CMD_QUERY: begin
                            if (unit_rsp.hit) begin
                                n_hit     = 1'b1;
                                n_hit_idx = unit_rsp.idx;
                                n_state   = S_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                // Every entry has passed the unit.
                if (r_ptr >= r_count && !r_rd_vld && !unit_rsp.vld) begin
                    n_state = S_DONE;
                    if (r_cmd == CMD_DELETE) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end

            S_DONE: begin
                // Load the response once the output register is free.
                if (!r_out_vld || o_rsp_ch.ready) begin
                    n_out_vld    = 1'b1;
                    n_out_hit    = r_hit;
                    n_out_idx    = r_hit_idx;
                    n_out_count  = r_count;
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_rd_vld = rd_en;
        n_rd_idx = rd_addr;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ptr     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ptr     <= n_ptr;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_qx         <= n_qx;
        r_qy         <= n_qy;
        r_qw         <= n_qw;
        r_qh         <= n_qh;
        r_kind       <= n_kind;
        r_slot       <= n_slot;
        r_dx         <= n_dx;
        r_dy         <= n_dy;
        r_query      <= n_query;
        r_rd_idx     <= n_rd_idx;
        r_hit        <= n_hit;
        r_hit_idx    <= n_hit_idx;
        r_status     <= n_status;
        r_out_hit    <= n_out_hit;
        r_out_idx    <= n_out_idx;
        r_out_count  <= n_out_count;
        r_out_status <= n_out_status;
    end

    // Response channel.
    assign o_rsp_ch.valid       = r_out_vld;
    assign o_rsp_ch.hit         = r_out_hit;
    assign o_rsp_ch.hit_slot    = HSLOT_W'(r_out_idx);
    assign o_rsp_ch.entry_count = COUNT_W'(r_out_count);
    assign o_rsp_ch.status      = r_out_status;

`ifndef ASSERT_OFF
    // The entry count never passes the table size.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table size");

    // The memory is never written while waiting for a command.
    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !wr_en)
        else $error("memory write while idle");

    // An accepted command is executed in the following cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == S_EXEC))
        else $error("accepted command not executed");

    // The count moves by at most one entry per command.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |->
            (r_count == $past(r_count) + CNT_W'(1) || r_count == $past(r_count) - CNT_W'(1)))
        else $error("entry count jumped");
`endif

endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the rectangle table collision scanner
// Sends add, delete, move and query words into the block and keeps its own
// copy of the rectangle table to work out the reply to every accepted word.
// Each reply is checked field by field against the oldest outstanding one.
// Both channels idle in random bursts, and the reply side holds off once for
// a long stretch so that the block backs up into its command channel.
// ----------------------------------------------------------------------------
module testbench import rtcs_pkg::*; ();

    localparam int LIMIT_CYCLES = 800000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 80;
    localparam int MAX_REPORTS  = 40;

    // One command word as offered on the command channel.
    typedef struct {
        t_cmd                     op;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic [DIM_W-1:0]         w;
        logic [DIM_W-1:0]         h;
        logic [KIND_W-1:0]        kind;
        logic [SLOT_W-1:0]        slot;
        logic signed [POS_W-1:0]  dx;
        logic signed [POS_W-1:0]  dy;
    } t_word;

    // One reply word as returned on the reply channel.
    typedef struct {
        logic                hit;
        logic [HSLOT_W-1:0]  hit_slot;
        logic [COUNT_W-1:0]  count;
        t_status             status;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;

    rtcs_cmd_if cmd_ch();
    rtcs_rsp_if rsp_ch();

    rect_table_collision_scan dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd_ch (cmd_ch),
        .o_rsp_ch (rsp_ch)
    );

    // Local copy of the rectangle table.
    logic signed [COORD_W-1:0] tbl_x    [MAX_ENTRIES];
    logic signed [COORD_W-1:0] tbl_y    [MAX_ENTRIES];
    logic [DIM_W-1:0]          tbl_w    [MAX_ENTRIES];
    logic [DIM_W-1:0]          tbl_h    [MAX_ENTRIES];
    logic [KIND_W-1:0]         tbl_kind [MAX_ENTRIES];
    int                        tbl_count;

    t_reply pending_replies[$];
    int     errors;
    int     cycle_count;
    bit     idle_on;
    bit     hold_req;

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Cycle counter and run limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Print one line per mismatch, up to a cap, and count every one.
    task automatic flag_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want);
        end
    endtask

    // Saturate a value to the signed coordinate range.
    function automatic logic signed [COORD_W-1:0] sat_coord(input longint v);
        longint top;
        top = (longint'(1) <<< (COORD_W - 1)) - 1;
        if (v > top) begin
            v = top;
        end else if (v < -top - 1) begin
            v = -top - 1;
        end
        return COORD_W'(v);
    endfunction

    // Strict per-axis overlap of a query rectangle with table entry i.
    function automatic bit rect_hits(input longint qx, input longint qy,
                                     input longint qw, input longint qh, input int i);
        longint mx, my, mr, mb, qr, qb;
        bit     xo, yo;
        mx = tbl_x[i];
        my = tbl_y[i];
        mr = mx + longint'(tbl_w[i]);
        mb = my + longint'(tbl_h[i]);
        qr = qx + qw;
        qb = qy + qh;
        xo = (qr < mr && qr > mx) || (qx > mx && qx < mr) || (qx < mx && qr > mr);
        yo = (qy < mb && qy > my) || (qb < mb && qb > my) || (qy < my && qb > mb);
        return xo && yo;
    endfunction

    // Apply one accepted word to the local table and return its reply.
    function automatic t_reply predict_reply(input t_word wd);
        t_reply r;
        longint qx, qy;
        r.hit      = 1'b0;
        r.hit_slot = '0;
        r.status   = ST_OK;
        qx = sat_coord(longint'(wd.px));
        qy = sat_coord(longint'(wd.py));
        case (wd.op)
            CMD_ADD: begin
                if (tbl_count >= MAX_ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    tbl_x[tbl_count]    = COORD_W'(qx);
                    tbl_y[tbl_count]    = COORD_W'(qy);
                    tbl_w[tbl_count]    = wd.w;
                    tbl_h[tbl_count]    = wd.h;
                    tbl_kind[tbl_count] = wd.kind;
                    tbl_count++;
                end
            end
            CMD_DELETE: begin
                if (int'(wd.slot) >= tbl_count) begin
                    r.status = ST_BAD_SLOT;
                end else begin
                    for (int i = int'(wd.slot); i + 1 < tbl_count; i++) begin
                        tbl_x[i]    = tbl_x[i+1];
                        tbl_y[i]    = tbl_y[i+1];
                        tbl_w[i]    = tbl_w[i+1];
                        tbl_h[i]    = tbl_h[i+1];
                        tbl_kind[i] = tbl_kind[i+1];
                    end
                    tbl_count--;
                end
            end
            CMD_MOVE: begin
                for (int i = 0; i < tbl_count; i++) begin
                    tbl_x[i] = sat_coord(longint'(tbl_x[i]) + longint'(wd.dx));
                    tbl_y[i] = sat_coord(longint'(tbl_y[i]) + longint'(wd.dy));
                end
            end
            default: begin
                for (int i = 0; i < tbl_count; i++) begin
                    if (rect_hits(qx, qy, longint'(wd.w), longint'(wd.h), i)) begin
                        r.hit      = 1'b1;
                        r.hit_slot = HSLOT_W'(i);
                        break;
                    end
                end
            end
        endcase
        r.count = COUNT_W'(tbl_count);
        return r;
    endfunction

    // Offer one word, wait for its handshake and record the reply it owes.
    task automatic send_word(input t_word wd);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= wd.op;
        cmd_ch.pos_x   <= wd.px;
        cmd_ch.pos_y   <= wd.py;
        cmd_ch.width   <= wd.w;
        cmd_ch.height  <= wd.h;
        cmd_ch.kind    <= wd.kind;
        cmd_ch.slot    <= wd.slot;
        cmd_ch.delta_x <= wd.dx;
        cmd_ch.delta_y <= wd.dy;
        do @(posedge i_clk); while (cmd_ch.ready !== 1'b1);
        pending_replies.insert(pending_replies.size(), predict_reply(wd));
    endtask

    function automatic t_word make_word(input t_cmd op, input int px, input int py,
                                        input int w, input int h, input int kind,
                                        input int slot, input int dx, input int dy);
        t_word wd;
        wd.op   = op;
        wd.px   = POS_W'(px);
        wd.py   = POS_W'(py);
        wd.w    = DIM_W'(w);
        wd.h    = DIM_W'(h);
        wd.kind = KIND_W'(kind);
        wd.slot = SLOT_W'(slot);
        wd.dx   = POS_W'(dx);
        wd.dy   = POS_W'(dy);
        return wd;
    endfunction

    // Coordinates cluster near the origin so that rectangles meet, with some
    // full-range values and some close to either end of the range.
    function automatic logic signed [POS_W-1:0] pick_coord();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 14) return POS_W'(int'($urandom_range(0, 600)) - 300);
        if (sel < 17) return POS_W'($urandom);
        if (sel < 18) return POS_W'(32767 - int'($urandom_range(0, 200)));
        return POS_W'(-32768 + int'($urandom_range(0, 200)));
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int unsigned sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return DIM_W'($urandom_range(0, 150));
        if (sel < 8) return DIM_W'($urandom);
        return DIM_W'($urandom_range(0, 3));
    endfunction

    function automatic logic signed [POS_W-1:0] pick_delta();
        int unsigned sel;
        sel = $urandom_range(0, 19);
        if (sel < 12) return POS_W'(int'($urandom_range(0, 100)) - 50);
        if (sel < 17) return POS_W'($urandom);
        if (sel < 18) return POS_W'(32767);
        return POS_W'(-32768);
    endfunction

    // Command mix that keeps the table mostly small but busy.
    function automatic t_cmd pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (tbl_count < 4) begin
            if (r < 60) return CMD_ADD;
            if (r < 70) return CMD_DELETE;
            if (r < 80) return CMD_MOVE;
            return CMD_QUERY;
        end else if (tbl_count > 20) begin
            if (r < 15) return CMD_ADD;
            if (r < 50) return CMD_DELETE;
            if (r < 65) return CMD_MOVE;
            return CMD_QUERY;
        end
        if (r < 30) return CMD_ADD;
        if (r < 45) return CMD_DELETE;
        if (r < 60) return CMD_MOVE;
        return CMD_QUERY;
    endfunction

    // Random word; every field carries random bits whether the command uses it.
    function automatic t_word random_word(input t_cmd op);
        t_word wd;
        int    i;
        wd.op   = op;
        wd.px   = pick_coord();
        wd.py   = pick_coord();
        wd.w    = pick_dim();
        wd.h    = pick_dim();
        wd.kind = KIND_W'($urandom);
        wd.slot = SLOT_W'($urandom);
        wd.dx   = pick_delta();
        wd.dy   = pick_delta();
        if (op == CMD_DELETE && tbl_count > 0 && $urandom_range(0, 99) < 85) begin
            wd.slot = SLOT_W'($urandom_range(0, tbl_count - 1));
        end
        // Aim half of the queries at a stored rectangle so that hits are common.
        if (op == CMD_QUERY && tbl_count > 0 && $urandom_range(0, 1) == 1) begin
            i     = $urandom_range(0, tbl_count - 1);
            wd.px = sat_coord(longint'(tbl_x[i]) + longint'(int'($urandom_range(0, 40)) - 20));
            wd.py = sat_coord(longint'(tbl_y[i]) + longint'(int'($urandom_range(0, 40)) - 20));
            wd.w  = DIM_W'($urandom_range(0, 60));
            wd.h  = DIM_W'($urandom_range(0, 60));
        end
        return wd;
    endfunction

    // Edge cases of every command on a small table.
    task automatic test_directed();
        send_word(make_word(CMD_QUERY,  0, 0, 10, 10, 0, 0, 0, 0));
        send_word(make_word(CMD_DELETE, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_MOVE,   0, 0, 0, 0, 0, 0, 5, -5));
        send_word(make_word(CMD_ADD, -32768, -32768, 32767, 32767, 255, 63, -1, -1));
        send_word(make_word(CMD_ADD, 32767, 32767, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_ADD, 0, 0, 10, 10, 'hA5, 0, 0, 0));
        send_word(make_word(CMD_ADD, 100, 100, 20, 20, 'h5A, 0, 0, 0));
        // Identical, inside, enclosing and edge-touching queries.
        send_word(make_word(CMD_QUERY, 0, 0, 10, 10, 0, 0, 0, 0));
        send_word(make_word(CMD_QUERY, 5, 5, 1, 1, 0, 0, 0, 0));
        send_word(make_word(CMD_QUERY, -5, -5, 20, 20, 0, 0, 0, 0));
        send_word(make_word(CMD_QUERY, 10, 0, 5, 5, 0, 0, 0, 0));
        send_word(make_word(CMD_QUERY, 2, 10, 3, 4, 0, 0, 0, 0));
        send_word(make_word(CMD_QUERY, -32768, -32768, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_QUERY, 32767, 32767, 32767, 32767, 0, 0, 0, 0));
        // Moves that saturate at both ends of the range.
        send_word(make_word(CMD_MOVE, 0, 0, 0, 0, 0, 0, 32767, 32767));
        send_word(make_word(CMD_QUERY, 32700, 32700, 100, 100, 0, 0, 0, 0));
        send_word(make_word(CMD_MOVE, 0, 0, 0, 0, 0, 0, -32768, -32768));
        send_word(make_word(CMD_MOVE, 0, 0, 0, 0, 0, 0, -32768, -32768));
        send_word(make_word(CMD_QUERY, -32768, -32768, 32767, 32767, 0, 0, 0, 0));
        // Bad slots, then removal of the last and the first entry.
        send_word(make_word(CMD_DELETE, 0, 0, 0, 0, 0, 63, 0, 0));
        send_word(make_word(CMD_DELETE, 0, 0, 0, 0, 0, 4, 0, 0));
        send_word(make_word(CMD_DELETE, 0, 0, 0, 0, 0, 3, 0, 0));
        send_word(make_word(CMD_DELETE, 0, 0, 0, 0, 0, 0, 0, 0));
        send_word(make_word(CMD_QUERY, -32768, -32768, 32767, 32767, 0, 0, 0, 0));
    endtask

    // Fill the table, add past full, work on the full table, then drain it.
    task automatic test_table_full();
        t_word wd;
        while (tbl_count < MAX_ENTRIES) send_word(random_word(CMD_ADD));
        repeat (3) send_word(random_word(CMD_ADD));
        repeat (4) send_word(random_word(CMD_QUERY));
        send_word(random_word(CMD_MOVE));
        wd      = random_word(CMD_DELETE);
        wd.slot = SLOT_W'(tbl_count - 1);
        send_word(wd);
        wd      = random_word(CMD_DELETE);
        wd.slot = '0;
        send_word(wd);
        while (tbl_count > 6) send_word(random_word(CMD_DELETE));
    endtask

    // The reply side holds off while words keep coming.
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (12) send_word(random_word(pick_op()));
        idle_on  = 1'b1;
    endtask

    // Random mix in blocks, most with idling and some without.
    task automatic test_random_mix(input int n_items);
        for (int k = 0; k < n_items; k++) begin
            if (k % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_word(random_word(pick_op()));
        end
    endtask

    // Back-to-back words with no idling on either side.
    task automatic test_streaming(input int n_items);
        idle_on = 1'b0;
        repeat (n_items) send_word(random_word(pick_op()));
    endtask

    // Reply side: random stall bursts and one long hold when requested.
    initial begin : reply_drain
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                rsp_ch.ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Check every accepted reply word against the oldest outstanding one.
    always @(posedge i_clk) begin : check_replies
        t_reply want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_replies.size() == 0) begin
                flag_mismatch("reply word with none outstanding, entry_count",
                              int'(rsp_ch.entry_count), -1);
            end else begin
                want = pending_replies.pop_front();
                if (rsp_ch.hit !== want.hit) begin
                    flag_mismatch("hit", int'(rsp_ch.hit), int'(want.hit));
                end
                if (rsp_ch.hit_slot !== want.hit_slot) begin
                    flag_mismatch("hit_slot", int'(rsp_ch.hit_slot), int'(want.hit_slot));
                end
                if (rsp_ch.entry_count !== want.count) begin
                    flag_mismatch("entry_count", int'(rsp_ch.entry_count), int'(want.count));
                end
                if (rsp_ch.status !== want.status) begin
                    flag_mismatch("status", int'(rsp_ch.status), int'(want.status));
                end
            end
        end
    end

    initial begin
        errors      = 0;
        cycle_count = 0;
        tbl_count   = 0;
        idle_on     = 1'b1;
        hold_req    = 1'b0;
        i_rst_n        <= 1'b0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_ADD;
        cmd_ch.pos_x   <= '0;
        cmd_ch.pos_y   <= '0;
        cmd_ch.width   <= '0;
        cmd_ch.height  <= '0;
        cmd_ch.kind    <= '0;
        cmd_ch.slot    <= '0;
        cmd_ch.delta_x <= '0;
        cmd_ch.delta_y <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_table_full();
        test_backpressure();
        test_random_mix(1100);
        test_streaming(100);

        // Wait for the last replies, then a little longer for stray words.
        cmd_ch.valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
